// File: design/qrs_pkg.sv
// Shared constants and result kind codes for the quadratic root solver.
package qrs_pkg;

	localparam int WORD_BITS_DEF = 32;
	localparam int FRACTION_BITS_DEF = 16;

	typedef enum logic [1:0] {
		KIND_DOUBLE  = 2'd0,
		KIND_REAL    = 2'd1,
		KIND_COMPLEX = 2'd2,
		KIND_NO_LEAD = 2'd3
	} kind_t;

endpackage

// File: design/qrs_sqrt_cell.sv
// One stage of the digit-by-digit square root chain, two radicand bits per stage.
module qrs_sqrt_cell
	import qrs_pkg::*;
#(
	parameter int XW = 66,
	parameter int RTW = 33,
	parameter int REMW = 36,
	parameter int TW = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            vld_i,
	input  logic [XW-1:0]   x_i,
	input  logic [REMW-1:0] rem_i,
	input  logic [RTW-1:0]  root_i,
	input  logic [TW-1:0]   tag_i,
	output logic            vld_o,
	output logic [XW-1:0]   x_o,
	output logic [REMW-1:0] rem_o,
	output logic [RTW-1:0]  root_o,
	output logic [TW-1:0]   tag_o
);

	logic [REMW-1:0] rem_sh;
	logic [REMW-1:0] trial;
	logic            ge;
	logic            vld_q;
	logic [XW-1:0]   x_q;
	logic [REMW-1:0] rem_q;
	logic [RTW-1:0]  root_q;
	logic [TW-1:0]   tag_q;

	assign rem_sh = {rem_i[REMW-3:0], x_i[XW-1 -: 2]};
	assign trial  = REMW'({root_i, 2'b01});
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q    <= {x_i[XW-3:0], 2'b00};
			rem_q  <= ge ? (rem_sh - trial) : rem_sh;
			root_q <= {root_i[RTW-2:0], ge};
			tag_q  <= tag_i;
		end
	end

	assign vld_o  = vld_q;
	assign x_o    = x_q;
	assign rem_o  = rem_q;
	assign root_o = root_q;
	assign tag_o  = tag_q;

endmodule

// File: design/qrs_div_cell.sv
// One stage of the restoring division chain, one quotient bit per stage for two lanes.
module qrs_div_cell
	import qrs_pkg::*;
#(
	parameter int NW = 52,
	parameter int DVW = 34,
	parameter int TW = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           vld_i,
	input  logic [NW-1:0]  n1_i,
	input  logic [NW-1:0]  n2_i,
	input  logic [DVW-1:0] r1_i,
	input  logic [DVW-1:0] r2_i,
	input  logic [NW-1:0]  q1_i,
	input  logic [NW-1:0]  q2_i,
	input  logic [DVW-1:0] dv_i,
	input  logic [TW-1:0]  tag_i,
	output logic           vld_o,
	output logic [NW-1:0]  n1_o,
	output logic [NW-1:0]  n2_o,
	output logic [DVW-1:0] r1_o,
	output logic [DVW-1:0] r2_o,
	output logic [NW-1:0]  q1_o,
	output logic [NW-1:0]  q2_o,
	output logic [DVW-1:0] dv_o,
	output logic [TW-1:0]  tag_o
);

	function automatic logic [DVW:0] div_step(input logic [DVW-1:0] r, input logic b,
			input logic [DVW-1:0] d);
		logic [DVW:0] rs;
		logic [DVW:0] diff;
		logic         ge;
		rs   = {r, b};
		diff = rs - {1'b0, d};
		ge   = rs >= {1'b0, d};
		return {ge, ge ? diff[DVW-1:0] : rs[DVW-1:0]};
	endfunction

	logic [DVW:0]   st1;
	logic [DVW:0]   st2;
	logic           vld_q;
	logic [NW-1:0]  n1_q;
	logic [NW-1:0]  n2_q;
	logic [DVW-1:0] r1_q;
	logic [DVW-1:0] r2_q;
	logic [NW-1:0]  q1_q;
	logic [NW-1:0]  q2_q;
	logic [DVW-1:0] dv_q;
	logic [TW-1:0]  tag_q;

	assign st1 = div_step(r1_i, n1_i[NW-1], dv_i);
	assign st2 = div_step(r2_i, n2_i[NW-1], dv_i);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n1_q  <= {n1_i[NW-2:0], 1'b0};
			n2_q  <= {n2_i[NW-2:0], 1'b0};
			r1_q  <= st1[DVW-1:0];
			r2_q  <= st2[DVW-1:0];
			q1_q  <= {q1_i[NW-2:0], st1[DVW]};
			q2_q  <= {q2_i[NW-2:0], st2[DVW]};
			dv_q  <= dv_i;
			tag_q <= tag_i;
		end
	end

	assign vld_o = vld_q;
	assign n1_o  = n1_q;
	assign n2_o  = n2_q;
	assign r1_o  = r1_q;
	assign r2_o  = r2_q;
	assign q1_o  = q1_q;
	assign q2_o  = q2_q;
	assign dv_o  = dv_q;
	assign tag_o = tag_q;

endmodule

// File: design/quadratic_root_solver.sv
// Top level of the pipelined quadratic root solver.
// Pipeline registers in order: input, product, discriminant, WORD_BITS + 1 square root cells,
// numerator, WORD_BITS + FRACTION_BITS + 4 divider cells and the output register.
// Throughput is one transaction per cycle; a held result freezes the whole chain.
// Reset clears only the valid bits of the stages and of the output.
module quadratic_root_solver
	import qrs_pkg::*;
#(
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        coef_valid,
	output logic                        coef_ready,
	input  logic signed [WORD_BITS-1:0] a_coef,
	input  logic signed [WORD_BITS-1:0] b_coef,
	input  logic signed [WORD_BITS-1:0] c_coef,
	output logic                        root_valid,
	input  logic                        root_ready,
	output logic [1:0]                  root_kind,
	output logic signed [WORD_BITS-1:0] first_value,
	output logic signed [WORD_BITS-1:0] second_value,
	output logic                        saturated
);

	localparam int W = WORD_BITS;
	localparam int F = FRACTION_BITS;
	localparam int DSW = 2 * W + 2;
	localparam int RTW = W + 1;
	localparam int REMW = W + 4;
	localparam int NSQ = W + 1;
	localparam int NMW = W + 2;
	localparam int NW = W + F + 4;
	localparam int DVW = W + 2;
	localparam int NDIV = NW;
	localparam logic [NW-1:0] HALF = NW'(1) << (W - 1);
	localparam logic [NW-1:0] EPS = NW'(((64'd1 << F) - 64'd1) / 64'd100000000);

	typedef struct packed {
		logic         zero_a;
		kind_t        kind;
		logic         pn;
		logic [W-1:0] pm;
		logic [W:0]   den;
	} side_a_t;

	typedef struct packed {
		logic  zero_a;
		kind_t kind;
		logic  neg1;
		logic  neg2;
		logic  tiny1;
	} side_b_t;

	localparam int TWA = $bits(side_a_t);
	localparam int TWB = $bits(side_b_t);

	logic en;

	logic         v_s1;
	logic         an_s1, bn_s1, cn_s1;
	logic [W-1:0] ma_s1, mb_s1, mc_s1;

	logic           v_s2;
	logic           an_s2, bn_s2, cn_s2;
	logic [W-1:0]   ma_s2, mb_s2;
	logic [2*W-1:0] b2_s2, ac_s2;

	logic [DSW-1:0] b2_ext, ac4, dm_c;
	logic           dneg_c;
	side_a_t        side_c;

	logic           sq_v    [0:NSQ];
	logic [DSW-1:0] sq_x    [0:NSQ];
	logic [REMW-1:0] sq_rem [0:NSQ];
	logic [RTW-1:0] sq_root [0:NSQ];
	logic [TWA-1:0] sq_tag  [0:NSQ];

	side_a_t              sa;
	logic signed [W+2:0]  p_v, s_v, v1, v2, a1, a2;
	logic [NMW-1:0]       m1, m2;
	side_b_t              sb_c;

	logic           dv_v  [0:NDIV];
	logic [NW-1:0]  dv_n1 [0:NDIV];
	logic [NW-1:0]  dv_n2 [0:NDIV];
	logic [DVW-1:0] dv_r1 [0:NDIV];
	logic [DVW-1:0] dv_r2 [0:NDIV];
	logic [NW-1:0]  dv_q1 [0:NDIV];
	logic [NW-1:0]  dv_q2 [0:NDIV];
	logic [DVW-1:0] dv_d  [0:NDIV];
	logic [TWB-1:0] dv_tag [0:NDIV];

	side_b_t       sbo;
	logic [NW-1:0] lim1, lim2, m1o, m2o;
	logic          sat1, sat2;
	logic [W-1:0]  f_c, s_c;

	logic         out_v_q;
	logic [1:0]   kind_q;
	logic [W-1:0] first_q, second_q;
	logic         sat_q;

	assign en = !out_v_q || root_ready;
	assign coef_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			sq_v[0] <= 1'b0;
			dv_v[0] <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			v_s1 <= coef_valid;
			v_s2 <= v_s1;
			sq_v[0] <= v_s2;
			dv_v[0] <= sq_v[NSQ];
			out_v_q <= dv_v[NDIV];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			an_s1 <= a_coef[W-1];
			bn_s1 <= b_coef[W-1];
			cn_s1 <= c_coef[W-1];
			ma_s1 <= a_coef[W-1] ? W'(-a_coef) : W'(a_coef);
			mb_s1 <= b_coef[W-1] ? W'(-b_coef) : W'(b_coef);
			mc_s1 <= c_coef[W-1] ? W'(-c_coef) : W'(c_coef);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			an_s2 <= an_s1;
			bn_s2 <= bn_s1;
			cn_s2 <= cn_s1;
			ma_s2 <= ma_s1;
			mb_s2 <= mb_s1;
			b2_s2 <= mb_s1 * mb_s1;
			ac_s2 <= ma_s1 * mc_s1;
		end
	end

	always_comb begin
		b2_ext = DSW'(b2_s2);
		ac4    = {ac_s2, 2'b00};
		dneg_c = 1'b0;
		if (an_s2 != cn_s2) begin
			dm_c = b2_ext + ac4;
		end else if (b2_ext >= ac4) begin
			dm_c = b2_ext - ac4;
		end else begin
			dm_c   = ac4 - b2_ext;
			dneg_c = 1'b1;
		end
		side_c.zero_a = (ma_s2 == '0);
		side_c.pn     = (mb_s2 != '0) && (bn_s2 == an_s2);
		side_c.pm     = mb_s2;
		side_c.den    = {ma_s2, 1'b0};
		priority if (ma_s2 == '0) side_c.kind = KIND_NO_LEAD;
		else if (dm_c == '0) side_c.kind = KIND_DOUBLE;
		else if (dneg_c) side_c.kind = KIND_COMPLEX;
		else side_c.kind = KIND_REAL;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_x[0]    <= dm_c;
			sq_rem[0]  <= '0;
			sq_root[0] <= '0;
			sq_tag[0]  <= side_c;
		end
	end

	for (genvar i = 0; i < NSQ; i++) begin : g_sqrt
		qrs_sqrt_cell #(
			.XW(DSW), .RTW(RTW), .REMW(REMW), .TW(TWA)
		) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_i(sq_v[i]), .x_i(sq_x[i]), .rem_i(sq_rem[i]),
			.root_i(sq_root[i]), .tag_i(sq_tag[i]),
			.vld_o(sq_v[i+1]), .x_o(sq_x[i+1]), .rem_o(sq_rem[i+1]),
			.root_o(sq_root[i+1]), .tag_o(sq_tag[i+1])
		);
	end

	always_comb begin
		sa  = side_a_t'(sq_tag[NSQ]);
		p_v = sa.pn ? -$signed({3'b000, sa.pm}) : $signed({3'b000, sa.pm});
		s_v = $signed({2'b00, sq_root[NSQ]});
		sb_c.zero_a = sa.zero_a;
		sb_c.kind   = sa.kind;
		sb_c.tiny1  = 1'b0;
		unique case (sa.kind)
			KIND_REAL: begin
				v1 = p_v + s_v;
				v2 = p_v - s_v;
			end
			KIND_COMPLEX: begin
				v1 = p_v;
				v2 = s_v;
				sb_c.tiny1 = 1'b1;
			end
			KIND_DOUBLE, KIND_NO_LEAD: begin
				v1 = p_v;
				v2 = '0;
			end
			default: begin
				v1 = '0;
				v2 = '0;
			end
		endcase
		a1 = v1[W+2] ? -v1 : v1;
		a2 = v2[W+2] ? -v2 : v2;
		m1 = a1[NMW-1:0];
		m2 = a2[NMW-1:0];
		sb_c.neg1 = v1[W+2];
		sb_c.neg2 = v2[W+2];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_n1[0]  <= (NW'(m1) << (F + 1)) + NW'(sa.den);
			dv_n2[0]  <= (NW'(m2) << (F + 1)) + NW'(sa.den);
			dv_r1[0]  <= '0;
			dv_r2[0]  <= '0;
			dv_q1[0]  <= '0;
			dv_q2[0]  <= '0;
			dv_d[0]   <= {sa.den, 1'b0};
			dv_tag[0] <= sb_c;
		end
	end

	for (genvar j = 0; j < NDIV; j++) begin : g_div
		qrs_div_cell #(
			.NW(NW), .DVW(DVW), .TW(TWB)
		) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_i(dv_v[j]), .n1_i(dv_n1[j]), .n2_i(dv_n2[j]),
			.r1_i(dv_r1[j]), .r2_i(dv_r2[j]), .q1_i(dv_q1[j]), .q2_i(dv_q2[j]),
			.dv_i(dv_d[j]), .tag_i(dv_tag[j]),
			.vld_o(dv_v[j+1]), .n1_o(dv_n1[j+1]), .n2_o(dv_n2[j+1]),
			.r1_o(dv_r1[j+1]), .r2_o(dv_r2[j+1]), .q1_o(dv_q1[j+1]), .q2_o(dv_q2[j+1]),
			.dv_o(dv_d[j+1]), .tag_o(dv_tag[j+1])
		);
	end

	always_comb begin
		sbo  = side_b_t'(dv_tag[NDIV]);
		lim1 = sbo.neg1 ? HALF : HALF - NW'(1);
		lim2 = sbo.neg2 ? HALF : HALF - NW'(1);
		sat1 = dv_q1[NDIV] > lim1;
		sat2 = dv_q2[NDIV] > lim2;
		m1o  = sat1 ? lim1 : dv_q1[NDIV];
		m2o  = sat2 ? lim2 : dv_q2[NDIV];
		if (sbo.tiny1 && m1o <= EPS) begin
			m1o = '0;
		end
		f_c = sbo.neg1 ? W'(-m1o) : W'(m1o);
		s_c = sbo.neg2 ? W'(-m2o) : W'(m2o);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_q <= sbo.kind;
			if (sbo.zero_a) begin
				first_q  <= '0;
				second_q <= '0;
				sat_q    <= 1'b0;
			end else begin
				first_q  <= f_c;
				second_q <= s_c;
				sat_q    <= sat1 || sat2;
			end
		end
	end

	assign root_valid   = out_v_q;
	assign root_kind    = kind_q;
	assign first_value  = first_q;
	assign second_value = second_q;
	assign saturated    = sat_q;

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!root_valid |-> coef_ready)
		else $error("input stalled while the output register is empty");

	a_no_lead_zero: assert property (@(posedge clk) disable iff (!arst_n)
		root_valid && root_kind == KIND_NO_LEAD |->
		first_value == '0 && second_value == '0 && !saturated)
		else $error("zero leading coefficient gave nonzero results");

	a_complex_imag: assert property (@(posedge clk) disable iff (!arst_n)
		root_valid && root_kind == KIND_COMPLEX |-> !second_value[W-1])
		else $error("negative imaginary part");

	a_double_second: assert property (@(posedge clk) disable iff (!arst_n)
		root_valid && root_kind == KIND_DOUBLE |-> second_value == '0)
		else $error("double root with nonzero second value");

endmodule
